>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the billboard quad expander
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/bqe_pkg.sv
// ----------------------------------------------------------------------------
// bqe_pkg
// Types, widths and helper functions shared by the billboard quad expander
// ----------------------------------------------------------------------------
package bqe_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW0_X = 3'd0,
    REG_ROW0_Y = 3'd1,
    REG_ROW0_Z = 3'd2,
    REG_ROW1_X = 3'd3,
    REG_ROW1_Y = 3'd4,
    REG_ROW1_Z = 3'd5
  } cfg_reg_e;

  // datapath widths
  localparam int COEF_W  = 16;   // Q1.14 matrix and table entries
  localparam int COORD_W = 32;   // Q24.8 coordinates
  localparam int CR_W    = 41;   // c * r
  localparam int CRK_W   = 58;   // c * r * k
  localparam int LX_W    = 26;   // local x axis, Q.8
  localparam int LY_W    = 34;   // local y axis, Q.8
  localparam int PX_W    = 42;   // matrix entry * lx
  localparam int PY_W    = 50;   // matrix entry * ly
  localparam int SX_W    = 43;
  localparam int SY_W    = 51;
  localparam int BX_W    = 29;   // world x basis
  localparam int BY_W    = 37;   // world y basis
  localparam int VSUM_W  = 39;   // corner sum before clamping

  localparam logic signed [COEF_W-1:0] Q14_ONE  = 16'sd16384;
  localparam logic signed [COEF_W-1:0] Q14_ZERO = 16'sd0;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  // 2*pi in Q3.30
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [LX_W-1:0]    lx_t;
  typedef logic signed [LY_W-1:0]    ly_t;
  typedef logic signed [BX_W-1:0]    bx_t;
  typedef logic signed [BY_W-1:0]    by_t;

  typedef struct packed {
    coef_t [2:0] row0;
    coef_t [2:0] row1;
  } view_t;

  typedef struct packed {
    coord_t [2:0] origin;
    logic [7:0]   rotation;
    logic [23:0]  radius;
    logic [15:0]  stretch;
  } particle_t;

  typedef struct packed {
    coord_t [2:0] origin;
    coef_t        c;
    coef_t        s;
    logic [23:0]  radius;
    logic [15:0]  stretch;
  } lookup_t;

  typedef struct packed {
    coord_t [2:0] origin;
    lx_t          lx0;
    lx_t          lx1;
    ly_t          ly0;
    ly_t          ly1;
  } axes_t;

  typedef struct packed {
    coord_t [2:0] origin;
    bx_t [2:0]    bx;
    by_t [2:0]    by;
  } basis_t;

  typedef struct packed {
    logic [1:0] corner;
    coord_t     vertex_x;
    coord_t     vertex_y;
    coord_t     vertex_z;
    logic       tex_u;
    logic       tex_v;
    logic       last_corner;
  } vertex_t;

  // arithmetic shift right by n, round to nearest, ties away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned n);
    logic signed [63:0] half;
    logic signed [63:0] bias;
    half = 64'sd1 <<< (n - 1);
    bias = v[63] ? (half - 64'sd1) : half;
    return (v + bias) >>> n;
  endfunction

  // clamp a corner sum to the 32-bit coordinate range
  function automatic coord_t sat32(input logic signed [VSUM_W-1:0] v);
    logic [VSUM_W-COORD_W:0] top;
    top = v[VSUM_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      return v[COORD_W-1:0];
    end else if (v[VSUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/bqe_if.sv
// ----------------------------------------------------------------------------
// bqe_if
// Valid/ready channels for particles in and quad corners out
// ----------------------------------------------------------------------------
interface bqe_particle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic [7:0]         rotation;
  logic [23:0]        radius;
  logic [15:0]        stretch_y;

  modport source (
    output valid, origin_x, origin_y, origin_z, rotation, radius, stretch_y,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, rotation, radius, stretch_y,
    output ready
  );
endinterface

interface bqe_vertex_if;
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               tex_u;
  logic               tex_v;
  logic               last_corner;

  modport source (
    output valid, corner, vertex_x, vertex_y, vertex_z, tex_u, tex_v, last_corner,
    input  ready
  );
  modport sink (
    input  valid, corner, vertex_x, vertex_y, vertex_z, tex_u, tex_v, last_corner,
    output ready
  );
endinterface

>>> rtl/bqe_lookup.sv
// ----------------------------------------------------------------------------
// bqe_lookup
// Angle reduction and cosine/sine lookup, one register stage
// ----------------------------------------------------------------------------
module bqe_lookup #(
  parameter int ANGLE_STEPS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bqe_pkg::particle_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bqe_pkg::lookup_t    out_data
);
  import bqe_pkg::*;

  localparam int IW  = $clog2(ANGLE_STEPS);
  localparam int RW  = (IW + 1 > 8) ? IW + 1 : 8;
  localparam int QTR = ANGLE_STEPS / 4;

  coef_t            cos_rom [ANGLE_STEPS];
  logic [RW-1:0]    idx;
  logic [IW:0]      sin_sum;
  logic [IW-1:0]    cos_idx;
  logic [IW-1:0]    sin_idx;
  lookup_t          stage_next;

  // constant cosine table, one entry per angle step
  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rom
    localparam int unsigned K = (g <= QTR)     ? g :
                                (g <= 2 * QTR) ? 2 * QTR - g :
                                (g <= 3 * QTR) ? g - 2 * QTR :
                                                 ANGLE_STEPS - g;
    localparam bit NEG = (g > QTR) && (g <= 3 * QTR);
    localparam longint unsigned X =
      (64'(K) * TWO_PI_Q30 + 64'(ANGLE_STEPS / 2)) / 64'(ANGLE_STEPS);
    localparam longint unsigned X2  = (X * X) >> 30;
    // taylor terms of the cosine, each one built from the term before
    localparam longint unsigned T0  = 64'd1 << 30;
    localparam longint unsigned T1  = ((T0 * X2) >> 30) / 64'd2;
    localparam longint unsigned T2  = ((T1 * X2) >> 30) / 64'd12;
    localparam longint unsigned T3  = ((T2 * X2) >> 30) / 64'd30;
    localparam longint unsigned T4  = ((T3 * X2) >> 30) / 64'd56;
    localparam longint unsigned T5  = ((T4 * X2) >> 30) / 64'd90;
    localparam longint unsigned T6  = ((T5 * X2) >> 30) / 64'd132;
    localparam longint unsigned T7  = ((T6 * X2) >> 30) / 64'd182;
    localparam longint unsigned T8  = ((T7 * X2) >> 30) / 64'd240;
    localparam longint unsigned T9  = ((T8 * X2) >> 30) / 64'd306;
    localparam longint unsigned T10 = ((T9 * X2) >> 30) / 64'd380;
    localparam longint SUM = longint'(T0) - longint'(T1) + longint'(T2) - longint'(T3) +
                             longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7) +
                             longint'(T8) - longint'(T9) + longint'(T10);
    localparam longint SUM_POS = (SUM < 0) ? 64'sd0 : SUM;
    localparam coef_t MAG = COEF_W'((SUM_POS + 64'sd32768) >>> 16);
    localparam coef_t VAL = NEG ? -MAG : MAG;
    assign cos_rom[g] = VAL;
  end

  // rotation mod steps, then quarter-turn offset for the sine
  always_comb begin
    idx = RW'(in_data.rotation);
    for (int i = 0; i < 4; i++) begin
      if (idx >= RW'(ANGLE_STEPS)) begin
        idx = idx - RW'(ANGLE_STEPS);
      end
    end
    cos_idx = idx[IW-1:0];
    sin_sum = {1'b0, cos_idx} + (IW + 1)'(ANGLE_STEPS - QTR);
    if (sin_sum >= (IW + 1)'(ANGLE_STEPS)) begin
      sin_sum = sin_sum - (IW + 1)'(ANGLE_STEPS);
    end
    sin_idx = sin_sum[IW-1:0];
  end

  always_comb begin
    stage_next.origin  = in_data.origin;
    stage_next.c       = cos_rom[cos_idx];
    stage_next.s       = cos_rom[sin_idx];
    stage_next.radius  = in_data.radius;
    stage_next.stretch = in_data.stretch;
  end

  // stage register
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

>>> rtl/bqe_axes.sv
// ----------------------------------------------------------------------------
// bqe_axes
// Local quad axes from cos/sin, radius and stretch, three register stages
// ----------------------------------------------------------------------------
module bqe_axes (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bqe_pkg::lookup_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bqe_pkg::axes_t    out_data
);
  import bqe_pkg::*;

  // stage a: c*r and s*r
  logic                    a_valid;
  coord_t [2:0]            a_origin;
  logic [15:0]             a_k;
  logic signed [CR_W-1:0]  a_cr;
  logic signed [CR_W-1:0]  a_sr;
  logic signed [CR_W-1:0]  a_cr_next;
  logic signed [CR_W-1:0]  a_sr_next;

  // stage b: times k, and the rounded x axis
  logic                    b_valid;
  coord_t [2:0]            b_origin;
  logic signed [CRK_W-1:0] b_crk;
  logic signed [CRK_W-1:0] b_srk;
  lx_t                     b_lx0;
  lx_t                     b_lx1;
  logic signed [CRK_W-1:0] b_crk_next;
  logic signed [CRK_W-1:0] b_srk_next;

  axes_t                   out_next;
  logic                    en_a;
  logic                    en_b;
  logic                    en_c;

  // backward stall chain
  assign en_c     = !out_valid || out_ready;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) a_valid <= in_valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) out_valid <= b_valid;
    end
  end

  // stage a
  assign a_cr_next = $signed(in_data.c) * $signed({1'b0, in_data.radius});
  assign a_sr_next = $signed(in_data.s) * $signed({1'b0, in_data.radius});

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_origin <= in_data.origin;
      a_k      <= in_data.stretch;
      a_cr     <= a_cr_next;
      a_sr     <= a_sr_next;
    end
  end

  // stage b
  assign b_crk_next = a_cr * $signed({1'b0, a_k});
  assign b_srk_next = a_sr * $signed({1'b0, a_k});

  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      b_origin <= a_origin;
      b_crk    <= b_crk_next;
      b_srk    <= b_srk_next;
      b_lx0    <= LX_W'(round_shift(64'(a_cr), 14));
      b_lx1    <= LX_W'(round_shift(-(64'(a_sr)), 14));
    end
  end

  // stage c: rounded y axis
  always_comb begin
    out_next.origin = b_origin;
    out_next.lx0    = b_lx0;
    out_next.lx1    = b_lx1;
    out_next.ly0    = LY_W'(round_shift(64'(b_srk), 22));
    out_next.ly1    = LY_W'(round_shift(64'(b_crk), 22));
  end

  always_ff @(posedge clk) begin
    if (en_c && b_valid) begin
      out_data <= out_next;
    end
  end

endmodule

>>> rtl/bqe_transform.sv
// ----------------------------------------------------------------------------
// bqe_transform
// View matrix applied to the local axes, three register stages
// ----------------------------------------------------------------------------
module bqe_transform (
  input  logic              clk,
  input  logic              rst,
  input  bqe_pkg::view_t    view,
  input  logic              in_valid,
  output logic              in_ready,
  input  bqe_pkg::axes_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bqe_pkg::basis_t   out_data
);
  import bqe_pkg::*;

  // stage a: twelve products
  logic                    a_valid;
  coord_t [2:0]            a_origin;
  logic signed [PX_W-1:0]  a_px0 [3];
  logic signed [PX_W-1:0]  a_px1 [3];
  logic signed [PY_W-1:0]  a_py0 [3];
  logic signed [PY_W-1:0]  a_py1 [3];

  // stage b: row sums
  logic                    b_valid;
  coord_t [2:0]            b_origin;
  logic signed [SX_W-1:0]  b_sx [3];
  logic signed [SY_W-1:0]  b_sy [3];

  basis_t                  out_next;
  logic                    en_a;
  logic                    en_b;
  logic                    en_c;

  assign en_c     = !out_valid || out_ready;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) a_valid <= in_valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) out_valid <= b_valid;
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_origin <= in_data.origin;
      for (int j = 0; j < 3; j++) begin
        a_px0[j] <= $signed(view.row0[j]) * in_data.lx0;
        a_px1[j] <= $signed(view.row1[j]) * in_data.lx1;
        a_py0[j] <= $signed(view.row0[j]) * in_data.ly0;
        a_py1[j] <= $signed(view.row1[j]) * in_data.ly1;
      end
    end
  end

  // stage b
  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      b_origin <= a_origin;
      for (int j = 0; j < 3; j++) begin
        b_sx[j] <= SX_W'(a_px0[j]) + SX_W'(a_px1[j]);
        b_sy[j] <= SY_W'(a_py0[j]) + SY_W'(a_py1[j]);
      end
    end
  end

  // stage c: round back to Q.8
  always_comb begin
    out_next.origin = b_origin;
    for (int j = 0; j < 3; j++) begin
      out_next.bx[j] = BX_W'(round_shift(64'(b_sx[j]), 14));
      out_next.by[j] = BY_W'(round_shift(64'(b_sy[j]), 14));
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && b_valid) begin
      out_data <= out_next;
    end
  end

endmodule

>>> rtl/bqe_corners.sv
// ----------------------------------------------------------------------------
// bqe_corners
// Holds one quad basis and issues its four corners through an output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqe_corners (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bqe_pkg::basis_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bqe_pkg::vertex_t  out_data
);
  import bqe_pkg::*;

  logic                      hold_valid;
  basis_t                    hold;
  logic [1:0]                cnt;
  logic                      out_en;
  logic                      load;
  logic                      neg_x;
  logic                      neg_y;
  logic signed [VSUM_W-1:0]  vsum [3];
  logic signed [VSUM_W-1:0]  o_e  [3];
  logic signed [VSUM_W-1:0]  bx_e [3];
  logic signed [VSUM_W-1:0]  by_e [3];
  vertex_t                   out_next;

  // handshake between hold stage and output register
  assign out_en   = !out_valid || out_ready;
  assign load     = out_en && hold_valid;
  assign in_ready = !hold_valid || (load && cnt == CORNER_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cnt        <= CORNER_FIRST;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) hold_valid <= in_valid;
      if (load) cnt <= cnt + 2'd1;
      if (out_en) out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold <= in_data;
    end
  end

  // fan order: x negated on corners 0 and 3, y negated on corners 2 and 3
  assign neg_x = (cnt == 2'd0) || (cnt == CORNER_LAST);
  assign neg_y = cnt[1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      o_e[j]  = VSUM_W'($signed(hold.origin[j]));
      bx_e[j] = VSUM_W'($signed(hold.bx[j]));
      by_e[j] = VSUM_W'($signed(hold.by[j]));
      vsum[j] = o_e[j] + (neg_x ? -bx_e[j] : bx_e[j]) + (neg_y ? -by_e[j] : by_e[j]);
    end
    out_next.corner      = cnt;
    out_next.vertex_x    = sat32(vsum[0]);
    out_next.vertex_y    = sat32(vsum[1]);
    out_next.vertex_z    = sat32(vsum[2]);
    out_next.tex_u       = cnt[1] ^ cnt[0];
    out_next.tex_v       = cnt[1];
    out_next.last_corner = (cnt == CORNER_LAST);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= out_next;
    end
  end

  // corner sequencing checks
  `ASSERT_NEXT(a_corner_step, clk, rst, out_valid && out_ready && out_data.corner != CORNER_LAST, out_valid && out_data.corner == $past(out_data.corner) + 2'd1)
  `ASSERT_NEXT(a_quad_wrap, clk, rst, out_valid && out_ready && out_data.corner == CORNER_LAST, !out_valid || out_data.corner == CORNER_FIRST)
  `ASSERT_NEXT(a_new_quad, clk, rst, in_valid && in_ready, hold_valid && cnt == CORNER_FIRST)

endmodule

>>> rtl/billboard_quad_expander.sv
// A particle passes the lookup, axes and transform stages, the hold register and the
// corner output register. Throughput: one corner per cycle while the sink is ready;
// the single output register, issuing four corners per quad, paces the particles.
// The 7-stage arithmetic pipeline takes a new particle in every cycle until it backs up.
// Reset (synchronous, rst high) clears all valid bits and loads the identity view matrix;
// the cosine table is constant and needs no clearing pass.
// ----------------------------------------------------------------------------
// billboard_quad_expander
// Expands rotated sprite particles into four world-space quad corners
// ----------------------------------------------------------------------------
module billboard_quad_expander #(
  parameter int ANGLE_STEPS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bqe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bqe_pkg::CFG_DATA_W-1:0]     cfg_data,
  bqe_particle_if.sink                       particle,
  bqe_vertex_if.source                       vertex
);
  import bqe_pkg::*;

  view_t     view;
  particle_t in_data;
  logic      lk_valid;
  logic      lk_ready;
  lookup_t   lk_data;
  logic      ax_valid;
  logic      ax_ready;
  axes_t     ax_data;
  logic      bs_valid;
  logic      bs_ready;
  basis_t    bs_data;
  vertex_t   vq_data;

  // view matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view.row0[0] <= Q14_ONE;
      view.row0[1] <= Q14_ZERO;
      view.row0[2] <= Q14_ZERO;
      view.row1[0] <= Q14_ZERO;
      view.row1[1] <= Q14_ONE;
      view.row1[2] <= Q14_ZERO;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW0_X: view.row0[0] <= $signed(cfg_data);
        REG_ROW0_Y: view.row0[1] <= $signed(cfg_data);
        REG_ROW0_Z: view.row0[2] <= $signed(cfg_data);
        REG_ROW1_X: view.row1[0] <= $signed(cfg_data);
        REG_ROW1_Y: view.row1[1] <= $signed(cfg_data);
        REG_ROW1_Z: view.row1[2] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // particle transaction payload
  assign in_data.origin   = {particle.origin_z, particle.origin_y, particle.origin_x};
  assign in_data.rotation = particle.rotation;
  assign in_data.radius   = particle.radius;
  assign in_data.stretch  = particle.stretch_y;

  bqe_lookup #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_lookup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (particle.valid),
    .in_ready  (particle.ready),
    .in_data   (in_data),
    .out_valid (lk_valid),
    .out_ready (lk_ready),
    .out_data  (lk_data)
  );

  bqe_axes u_axes (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lk_valid),
    .in_ready  (lk_ready),
    .in_data   (lk_data),
    .out_valid (ax_valid),
    .out_ready (ax_ready),
    .out_data  (ax_data)
  );

  bqe_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .view      (view),
    .in_valid  (ax_valid),
    .in_ready  (ax_ready),
    .in_data   (ax_data),
    .out_valid (bs_valid),
    .out_ready (bs_ready),
    .out_data  (bs_data)
  );

  bqe_corners u_corners (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bs_valid),
    .in_ready  (bs_ready),
    .in_data   (bs_data),
    .out_valid (vertex.valid),
    .out_ready (vertex.ready),
    .out_data  (vq_data)
  );

  // corner transaction payload
  assign vertex.corner      = vq_data.corner;
  assign vertex.vertex_x    = vq_data.vertex_x;
  assign vertex.vertex_y    = vq_data.vertex_y;
  assign vertex.vertex_z    = vq_data.vertex_z;
  assign vertex.tex_u       = vq_data.tex_u;
  assign vertex.tex_v       = vq_data.tex_v;
  assign vertex.last_corner = vq_data.last_corner;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the billboard quad expander: sprite particles go in
// on a bursty valid/ready channel, and every quad corner that comes out is
// compared field by field against a fixed-point predictor of the rotation,
// view mapping and corner expansion, while the corner sink stalls on its own
// pattern. Directed corners and view extremes come first, then random sweeps.
// ----------------------------------------------------------------------------
module testbench;
  import bqe_pkg::*;

  localparam int ANGLE_STEPS     = 256;
  localparam int QUARTER_TURN    = ANGLE_STEPS / 4;
  localparam int CLK_HALF_NS     = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RAND_PHASES     = 5;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int TIMEOUT_NS      = 3_000_000;

  // indexes past the view matrix, writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    coord_t      ox;
    coord_t      oy;
    coord_t      oz;
    logic [7:0]  rotation;
    logic [23:0] radius;
    logic [15:0] stretch;
  } sprite_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bqe_particle_if sprite_ch ();
  bqe_vertex_if   corner_ch ();

  billboard_quad_expander #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .particle  (sprite_ch),
    .vertex    (corner_ch)
  );

  // predictor state: cosine table and view matrix copy
  int      cos_q14 [ANGLE_STEPS];
  coef_t   view_row0 [3];
  coef_t   view_row1 [3];
  vertex_t pending_corners [$];
  logic [5:0][CFG_DATA_W-1:0] next_view;

  int mismatches;
  int burst_left;
  int stall_tick = 0;

  // clock
  always begin
    clk = 1'b0;
    #(CLK_HALF_NS);
    clk = 1'b1;
    #(CLK_HALF_NS);
  end

  // cosine of k steps within the first quadrant, Q1.14, by Taylor series
  function automatic int cos_first_quadrant(input int unsigned k);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint          sum;
    ang  = (64'(k) * TWO_PI_Q30 + 64'(ANGLE_STEPS / 2)) / 64'(ANGLE_STEPS);
    ang2 = (ang * ang) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * ang2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum -= longint'(term);
      end else begin
        sum += longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return int'((sum + 64'sd32768) >>> 16);
  endfunction

  // shift right with round to nearest, ties away from zero
  function automatic longint round_half_away(input longint v, input int unsigned n);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return coord_t'(v);
  endfunction

  // expected four corners of one particle, queued in fan order
  function automatic void predict_quad(input sprite_t sp);
    longint  c, s, r, k;
    longint  lx0, lx1, ly0, ly1, sx, sy;
    longint  org [3];
    longint  bx [3];
    longint  by [3];
    int      ci, si;
    vertex_t v;
    ci  = sp.rotation % ANGLE_STEPS;
    si  = (ci + ANGLE_STEPS - QUARTER_TURN) % ANGLE_STEPS;
    c   = cos_q14[ci];
    s   = cos_q14[si];
    r   = longint'(sp.radius);
    k   = longint'(sp.stretch);
    lx0 = round_half_away(c * r, 14);
    lx1 = round_half_away(-s * r, 14);
    ly0 = round_half_away(s * r * k, 22);
    ly1 = round_half_away(c * r * k, 22);
    org[0] = sp.ox;
    org[1] = sp.oy;
    org[2] = sp.oz;
    for (int j = 0; j < 3; j++) begin
      bx[j] = round_half_away(longint'(view_row0[j]) * lx0 + longint'(view_row1[j]) * lx1, 14);
      by[j] = round_half_away(longint'(view_row0[j]) * ly0 + longint'(view_row1[j]) * ly1, 14);
    end
    for (int n = 0; n < 4; n++) begin
      sx = (n == 1 || n == 2) ? 1 : -1;
      sy = (n < 2) ? 1 : -1;
      v.corner      = 2'(n);
      v.vertex_x    = clamp_coord(org[0] + sx * bx[0] + sy * by[0]);
      v.vertex_y    = clamp_coord(org[1] + sx * bx[1] + sy * by[1]);
      v.vertex_z    = clamp_coord(org[2] + sx * bx[2] + sy * by[2]);
      v.tex_u       = (n == 1 || n == 2);
      v.tex_v       = (n >= 2);
      v.last_corner = (v.corner == CORNER_LAST);
      pending_corners.push_back(v);
    end
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic sprite_t make_sprite(input coord_t ox, input coord_t oy,
                                          input coord_t oz, input logic [7:0] rotation,
                                          input logic [23:0] radius,
                                          input logic [15:0] stretch);
    sprite_t sp;
    sp.ox       = ox;
    sp.oy       = oy;
    sp.oz       = oz;
    sp.rotation = rotation;
    sp.radius   = radius;
    sp.stretch  = stretch;
    return sp;
  endfunction

  // random field values, weighted toward small and extreme ranges
  function automatic coord_t rand_origin();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      1: return $urandom_range(0, 1) ? coord_t'(32'h7FFF_FFFF - $urandom_range(0, 32'hFFFF))
                                     : coord_t'(32'h8000_0000 + $urandom_range(0, 32'hFFFF));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'hFF_FFFF - 24'($urandom_range(0, 32'hFFF));
      default: return 24'($urandom_range(0, 32'h3_FFFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_stretch();
    case ($urandom_range(0, 2))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(192, 320));
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    coef_t v;
    case ($urandom_range(0, 2))
      0: v = coef_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = Q14_ONE;
          3: v = -Q14_ONE;
          default: v = Q14_ZERO;
        endcase
      end
      default: begin
        v = coef_t'($urandom_range(0, 32767));
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // one particle transaction, then a random gap at the end of a burst
  task automatic send_sprite(input sprite_t sp);
    int gap;
    sprite_ch.valid     <= 1'b1;
    sprite_ch.origin_x  <= sp.ox;
    sprite_ch.origin_y  <= sp.oy;
    sprite_ch.origin_z  <= sp.oz;
    sprite_ch.rotation  <= sp.rotation;
    sprite_ch.radius    <= sp.radius;
    sprite_ch.stretch_y <= sp.stretch;
    @(posedge clk);
    while (!sprite_ch.ready) @(posedge clk);
    predict_quad(sp);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        sprite_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold the sender until every queued corner has come out
  task automatic wait_quads_done();
    sprite_ch.valid <= 1'b0;
    while (pending_corners.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // write all six view registers, optionally followed by the spare indexes
  task automatic load_view(input logic [5:0][CFG_DATA_W-1:0] vals, input bit poke_spare);
    for (int i = REG_ROW0_X; i <= REG_ROW1_Z; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      case (cfg_reg_e'(i))
        REG_ROW0_X: view_row0[0] = vals[i];
        REG_ROW0_Y: view_row0[1] = vals[i];
        REG_ROW0_Z: view_row0[2] = vals[i];
        REG_ROW1_X: view_row1[0] = vals[i];
        REG_ROW1_Y: view_row1[1] = vals[i];
        REG_ROW1_Z: view_row1[2] = vals[i];
        default: ;
      endcase
    end
    if (poke_spare) begin
      for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
        cfg_write <= 1'b1;
        cfg_index <= CFG_INDEX_W'(i);
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
      end
    end
    cfg_write <= 1'b0;
  endtask

  // identity view from reset: zero quad, unit quad, quadrant angles, clamping
  task automatic test_reset_view();
    send_sprite(make_sprite(0, 0, 0, 8'd0, 24'd0, 16'd0));
    send_sprite(make_sprite(0, 0, 0, 8'd0, 24'h100, 16'h100));
    send_sprite(make_sprite(1000, -1000, 77, 8'd64, 24'h1000, 16'h180));
    send_sprite(make_sprite(1000, -1000, 77, 8'd128, 24'h1000, 16'h180));
    send_sprite(make_sprite(1000, -1000, 77, 8'd192, 24'h1000, 16'h180));
    send_sprite(make_sprite(1000, -1000, 77, 8'd255, 24'h1000, 16'h180));
    send_sprite(make_sprite(-5, 5, 0, 8'd32, 24'hFF_FFFF, 16'hFFFF));
    send_sprite(make_sprite(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            8'd0, 24'hFF_FFFF, 16'hFFFF));
    send_sprite(make_sprite(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            8'd128, 24'hFF_FFFF, 16'hFFFF));
    send_sprite(make_sprite(0, 0, 0, 8'd200, 24'hFF_FFFF, 16'd0));
    wait_quads_done();
  endtask

  // full-scale view entries of both signs, spare register writes ignored
  task automatic test_view_extremes();
    for (int i = REG_ROW0_X; i <= REG_ROW1_Z; i++) next_view[i] = 16'h8000;
    load_view(next_view, 1'b0);
    send_sprite(make_sprite(0, 0, 0, 8'd0, 24'hFF_FFFF, 16'hFFFF));
    send_sprite(make_sprite(rand_origin(), rand_origin(), rand_origin(),
                            8'd160, 24'h2345, 16'h0200));
    wait_quads_done();
    for (int i = REG_ROW0_X; i <= REG_ROW1_Z; i++) next_view[i] = 16'h7FFF;
    load_view(next_view, 1'b0);
    send_sprite(make_sprite(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 8'd96, 24'hFF_FFFF, 16'hFFFF));
    send_sprite(make_sprite(32'sh8000_0000, 32'sh8000_0000, 0, 8'd224, 24'h80_0000, 16'h8000));
    wait_quads_done();
    for (int i = REG_ROW0_X; i <= REG_ROW1_Z; i++) next_view[i] = (i % 2) ? 16'h8000 : 16'h7FFF;
    load_view(next_view, 1'b1);
    send_sprite(make_sprite(123456, -654321, 42, 8'd48, 24'hFF_FFFF, 16'hFFFF));
    send_sprite(make_sprite(0, 0, 0, 8'd176, 24'h00_0FFF, 16'h0100));
    wait_quads_done();
  endtask

  // random particles over several view settings, starting from identity
  task automatic test_random_sweep();
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        next_view[REG_ROW0_X] = Q14_ONE;
        next_view[REG_ROW0_Y] = Q14_ZERO;
        next_view[REG_ROW0_Z] = Q14_ZERO;
        next_view[REG_ROW1_X] = Q14_ZERO;
        next_view[REG_ROW1_Y] = Q14_ONE;
        next_view[REG_ROW1_Z] = Q14_ZERO;
      end else begin
        for (int i = REG_ROW0_X; i <= REG_ROW1_Z; i++) next_view[i] = rand_coef();
      end
      load_view(next_view, 1'($urandom_range(0, 1)));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sprite(make_sprite(rand_origin(), rand_origin(), rand_origin(),
                                8'($urandom), rand_radius(), rand_stretch()));
        // in phase 2 the sender holds off mid-phase until the output side drains
        if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
          wait_quads_done();
        end
      end
      wait_quads_done();
    end
  endtask

  // corner sink: stall pattern switches with bits 8 to 6 of a free-running tick counter
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[8:6])
      3'd0, 3'd1: corner_ch.ready <= 1'b1;
      3'd2: corner_ch.ready <= 1'($urandom_range(0, 1));
      3'd3: corner_ch.ready <= (stall_tick[1:0] == 2'd0);
      3'd4: corner_ch.ready <= (stall_tick[2:0] != 3'd7);
      3'd5: corner_ch.ready <= ($urandom_range(0, 7) == 0);
      3'd6: corner_ch.ready <= ~stall_tick[0];
      default: corner_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // compare each corner transaction with the oldest expected corner
  always @(posedge clk) begin : check_corners
    vertex_t got;
    vertex_t want;
    if (!rst && corner_ch.valid && corner_ch.ready) begin
      got.corner      = corner_ch.corner;
      got.vertex_x    = corner_ch.vertex_x;
      got.vertex_y    = corner_ch.vertex_y;
      got.vertex_z    = corner_ch.vertex_z;
      got.tex_u       = corner_ch.tex_u;
      got.tex_v       = corner_ch.tex_v;
      got.last_corner = corner_ch.last_corner;
      if (pending_corners.size() == 0) begin
        $error("corner %0d arrived with no quad pending", got.corner);
        mismatches++;
      end else begin
        want = pending_corners.pop_front();
        check_field("corner", want.corner, got.corner);
        check_field("vertex_x", want.vertex_x, got.vertex_x);
        check_field("vertex_y", want.vertex_y, got.vertex_y);
        check_field("vertex_z", want.vertex_z, got.vertex_z);
        check_field("tex_u", want.tex_u, got.tex_u);
        check_field("tex_v", want.tex_v, got.tex_v);
        check_field("last_corner", want.last_corner, got.last_corner);
      end
    end
  end

  // main sequence
  initial begin
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = REG_ROW0_X;
    cfg_data            = '0;
    sprite_ch.valid     = 1'b0;
    sprite_ch.origin_x  = '0;
    sprite_ch.origin_y  = '0;
    sprite_ch.origin_z  = '0;
    sprite_ch.rotation  = '0;
    sprite_ch.radius    = '0;
    sprite_ch.stretch_y = '0;
    corner_ch.ready     = 1'b0;
    mismatches          = 0;
    burst_left          = 1;

    // cosine table by quadrant symmetry, view matrix at its reset values
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      if (i <= QUARTER_TURN) begin
        cos_q14[i] = cos_first_quadrant(i);
      end else if (i <= 2 * QUARTER_TURN) begin
        cos_q14[i] = -cos_first_quadrant(2 * QUARTER_TURN - i);
      end else if (i <= 3 * QUARTER_TURN) begin
        cos_q14[i] = -cos_first_quadrant(i - 2 * QUARTER_TURN);
      end else begin
        cos_q14[i] = cos_first_quadrant(ANGLE_STEPS - i);
      end
    end
    view_row0 = '{Q14_ONE, Q14_ZERO, Q14_ZERO};
    view_row1 = '{Q14_ZERO, Q14_ONE, Q14_ZERO};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_view();
    test_view_extremes();
    test_random_sweep();

    wait_quads_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bqe_pkg.sv
rtl/bqe_if.sv
rtl/bqe_lookup.sv
rtl/bqe_axes.sv
rtl/bqe_transform.sv
rtl/bqe_corners.sv
rtl/billboard_quad_expander.sv
bench/testbench.sv
